### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold on every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

### rtl/i2cbs_pkg.sv
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Types, codes and helpers for the I2C bus master bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

   localparam int WAIT_COUNTER_BITS = 10;
   localparam int HALF_PERIOD_BITS  = 10;
   localparam logic [HALF_PERIOD_BITS-1:0] HALF_PERIOD_RESET = 10'd250;
   localparam logic [31:0] WAIT_MAX = (32'd1 << WAIT_COUNTER_BITS) - 32'd1;

   localparam int BYTE_BITS = 8;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // command codes
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_START   = 3'd1;
   localparam logic [2:0] ACT_STOP    = 3'd2;
   localparam logic [2:0] ACT_SEND    = 3'd3;
   localparam logic [2:0] ACT_RECEIVE = 3'd4;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_S_SCLH,
      PH_S_SDAL,
      PH_S_SCLL,
      PH_P_SCLH,
      PH_P_SDAH,
      PH_P_END,
      PH_T_LOW,
      PH_T_HIGH,
      PH_TA_LOW,
      PH_TA_HIGH,
      PH_TA_SAMPLE,
      PH_R_HIGH,
      PH_R_SAMPLE,
      PH_RA_HIGH,
      PH_RA_END
   } phase_type;

   typedef struct packed {
      phase_type                     phase;
      logic [WAIT_COUNTER_BITS-1:0]  wait_cnt;
      logic [3:0]                    bits_left;
      logic [BYTE_BITS-1:0]          shift_byte;
      logic                          ack_to_send;
      logic                          scl_level;
      logic                          sda_level;
      logic [BYTE_BITS-1:0]          last_rx_byte;
      logic                          last_nack;
   } seq_state_type;

   localparam seq_state_type SEQ_STATE_RESET = '{
      phase:        PH_IDLE,
      wait_cnt:     '0,
      bits_left:    '0,
      shift_byte:   '0,
      ack_to_send:  1'b0,
      scl_level:    1'b1,
      sda_level:    1'b1,
      last_rx_byte: '0,
      last_nack:    1'b0
   };

   // half period as a wait count: zero counts as one, clipped to counter range
   function automatic logic [WAIT_COUNTER_BITS-1:0] wait_load(
      input logic [HALF_PERIOD_BITS-1:0] hp
   );
      logic [31:0] n;
      n = 32'(hp);
      if (n == 32'd0) n = 32'd1;
      if (n > WAIT_MAX) n = WAIT_MAX;
      return n[WAIT_COUNTER_BITS-1:0];
   endfunction

endpackage

### rtl/i2cbs_step.sv
// ----------------------------------------------------------------------------
// i2cbs_step
// Next-state logic for one tick of the bit sequencer.
// ----------------------------------------------------------------------------
module i2cbs_step (
   input  i2cbs_pkg::seq_state_type                cur,
   input  logic [2:0]                              action,
   input  logic [7:0]                              tx_data,
   input  logic                                    master_ack,
   input  logic                                    sda_in,
   input  logic [i2cbs_pkg::HALF_PERIOD_BITS-1:0]  half_period,
   output i2cbs_pkg::seq_state_type                nxt,
   output logic                                    done
);
   import i2cbs_pkg::*;

   logic [WAIT_COUNTER_BITS-1:0] load_val;
   logic [WAIT_COUNTER_BITS-1:0] cnt_dec;
   logic [3:0]                   bits_dec;

   assign load_val = wait_load(half_period);
   assign cnt_dec  = (cur.wait_cnt != '0) ? cur.wait_cnt - 1'b1 : cur.wait_cnt;

   always_comb begin
      nxt      = cur;
      done     = 1'b0;
      bits_dec = (cur.bits_left != '0) ? cur.bits_left - 1'b1 : cur.bits_left;

      if (cur.phase != PH_IDLE) begin
         nxt.wait_cnt = cnt_dec;
         if (cnt_dec == '0) begin
            unique case (cur.phase)
               PH_S_SCLH: begin
                  nxt.scl_level = 1'b1; nxt.wait_cnt = load_val; nxt.phase = PH_S_SDAL;
               end
               PH_S_SDAL: begin
                  nxt.sda_level = 1'b0; nxt.wait_cnt = load_val; nxt.phase = PH_S_SCLL;
               end
               PH_S_SCLL: begin
                  nxt.scl_level = 1'b0; nxt.phase = PH_IDLE; done = 1'b1;
               end
               PH_P_SCLH: begin
                  nxt.scl_level = 1'b1; nxt.wait_cnt = load_val; nxt.phase = PH_P_SDAH;
               end
               PH_P_SDAH: begin
                  nxt.sda_level = 1'b1; nxt.wait_cnt = load_val; nxt.phase = PH_P_END;
               end
               PH_P_END: begin
                  nxt.phase = PH_IDLE; done = 1'b1;
               end
               PH_T_LOW: begin
                  nxt.scl_level  = 1'b0;
                  nxt.sda_level  = cur.shift_byte[BYTE_BITS-1];
                  nxt.shift_byte = {cur.shift_byte[BYTE_BITS-2:0], 1'b0};
                  nxt.bits_left  = bits_dec;
                  nxt.wait_cnt   = load_val;
                  nxt.phase      = PH_T_HIGH;
               end
               PH_T_HIGH: begin
                  nxt.scl_level = 1'b1;
                  nxt.wait_cnt  = load_val;
                  nxt.phase     = (cur.bits_left != '0) ? PH_T_LOW : PH_TA_LOW;
               end
               PH_TA_LOW: begin
                  nxt.scl_level = 1'b0; nxt.sda_level = 1'b1;
                  nxt.wait_cnt  = load_val; nxt.phase = PH_TA_HIGH;
               end
               PH_TA_HIGH: begin
                  nxt.scl_level = 1'b1; nxt.wait_cnt = load_val; nxt.phase = PH_TA_SAMPLE;
               end
               PH_TA_SAMPLE: begin
                  nxt.last_nack = sda_in;
                  nxt.scl_level = 1'b0;
                  nxt.phase     = PH_IDLE;
                  done          = 1'b1;
               end
               PH_R_HIGH: begin
                  nxt.scl_level = 1'b1; nxt.wait_cnt = load_val; nxt.phase = PH_R_SAMPLE;
               end
               PH_R_SAMPLE: begin
                  nxt.shift_byte = {cur.shift_byte[BYTE_BITS-2:0], sda_in};
                  nxt.bits_left  = bits_dec;
                  nxt.scl_level  = 1'b0;
                  nxt.wait_cnt   = load_val;
                  if (bits_dec != '0) begin
                     nxt.phase = PH_R_HIGH;
                  end else begin
                     nxt.sda_level = ~cur.ack_to_send;
                     nxt.phase     = PH_RA_HIGH;
                  end
               end
               PH_RA_HIGH: begin
                  nxt.scl_level = 1'b1; nxt.wait_cnt = load_val; nxt.phase = PH_RA_END;
               end
               PH_RA_END: begin
                  nxt.scl_level    = 1'b0;
                  nxt.last_rx_byte = cur.shift_byte;
                  nxt.phase        = PH_IDLE;
                  done             = 1'b1;
               end
               PH_IDLE: begin
                  nxt.phase = PH_IDLE;
               end
            endcase
         end
      end else begin
         // idle: take a new command, unknown codes do nothing
         unique case (action)
            ACT_START: begin
               nxt.sda_level = 1'b1; nxt.wait_cnt = load_val; nxt.phase = PH_S_SCLH;
            end
            ACT_STOP: begin
               nxt.sda_level = 1'b0; nxt.wait_cnt = load_val; nxt.phase = PH_P_SCLH;
            end
            ACT_SEND: begin
               // first bit changes SDA only
               nxt.sda_level  = tx_data[BYTE_BITS-1];
               nxt.shift_byte = {tx_data[BYTE_BITS-2:0], 1'b0};
               nxt.bits_left  = BITS_PER_BYTE - 1'b1;
               nxt.wait_cnt   = load_val;
               nxt.phase      = PH_T_HIGH;
            end
            ACT_RECEIVE: begin
               nxt.sda_level   = 1'b1;
               nxt.shift_byte  = '0;
               nxt.bits_left   = BITS_PER_BYTE;
               nxt.ack_to_send = master_ack;
               nxt.wait_cnt    = load_val;
               nxt.phase       = PH_R_HIGH;
            end
            default: begin
               nxt.phase = PH_IDLE;
            end
         endcase
      end
   end

endmodule

### rtl/i2c_bus_master_bit_sequencer.sv
// Response: registered; the rsp transaction appears in the cycle after its req is accepted.
// Throughput: one transaction per cycle while rsp_tready is high; each transaction is one bus
//   tick and the tick's whole state update is a single pass of logic into the state regs.
// Reset: synchronous, active high; sequencer goes idle with SCL high, SDA
//   released, half period 250 ticks, rsp channel empty.
// ----------------------------------------------------------------------------
// i2c_bus_master_bit_sequencer
// I2C master that turns start/stop/send/receive commands into SCL/SDA levels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_bus_master_bit_sequencer (
   input  logic        clock,
   input  logic        reset,
   // config: half period in ticks
   input  logic        csr_we,
   input  logic [9:0]  csr_wdata,
   // request: one transaction per bus tick
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] tx_data, [8] master_ack, [9] sda_in, rest 0
   input  logic [2:0]  req_tuser,   // [2:0] action
   // response: pin levels and status after the tick
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] scl_out, [1] sda_release, [2] busy_res,
                                    // [3] done_res, [11:4] rx_data, [12] nack_seen, rest 0
);
   import i2cbs_pkg::*;

   seq_state_type                  state_ff, state_in;
   logic [HALF_PERIOD_BITS-1:0]    half_period_ff;
   logic                           rsp_valid_ff;
   logic [15:0]                    rsp_data_ff, rsp_data_in;
   logic                           done;
   logic                           req_accept;
   logic                           seq_idle;
   logic                           start_take;
   logic                           none_take;

   // output register frees up when taken, so a new tick can enter every cycle while rsp_tready is high
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   i2cbs_step u_step (
      .cur         (state_ff),
      .action      (req_tuser),
      .tx_data     (req_tdata[7:0]),
      .master_ack  (req_tdata[8]),
      .sda_in      (req_tdata[9]),
      .half_period (half_period_ff),
      .nxt         (state_in),
      .done        (done)
   );

   // result is taken from the state after this tick
   assign rsp_data_in = {3'b000,
                         state_in.last_nack,
                         state_in.last_rx_byte,
                         done,
                         (state_in.phase != PH_IDLE),
                         state_in.sda_level,
                         state_in.scl_level};

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_we) begin
         half_period_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // shorthands for the checks below
   assign seq_idle   = (state_ff.phase == PH_IDLE);
   assign start_take = req_accept && seq_idle && (req_tuser == ACT_START);
   assign none_take  = req_accept && seq_idle && (req_tuser == ACT_NONE);

   // a busy sequencer always has a wait loaded
   `ASSERT_NEVER(a_busy_wait, clock, reset, !seq_idle && (state_ff.wait_cnt == '0), "no wait")
   // bit counter never exceeds one byte
   `ASSERT_NEVER(a_bits_range, clock, reset, state_ff.bits_left > BITS_PER_BYTE, "bits range")
   // start from idle enters the SCL-high step
   `ASSERT_ALWAYS(a_start_entry, clock, reset, start_take |=> (state_ff.phase == PH_S_SCLH), "no start")
   // no command from idle leaves the sequencer idle
   `ASSERT_ALWAYS(a_idle_hold, clock, reset, none_take |=> seq_idle, "idle left without command")

endmodule

### tb/i2c_bus_master_bit_sequencer_tb.sv
// ----------------------------------------------------------------------------
// i2c_bus_master_bit_sequencer_tb
// Drives bus ticks with start, stop, send and receive commands plus random
// noise at several half-period settings. A cycle-level predictor tracks the
// sequencer and every rsp transaction is checked field by field against it.
// ----------------------------------------------------------------------------
module i2c_bus_master_bit_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cbs_pkg::*;

   // expected pin levels and status after one tick, packed as rsp_tdata[12:0]
   typedef struct packed {
      logic       nack;
      logic [7:0] rx;
      logic       done;
      logic       busy;
      logic       sda_rel;
      logic       scl;
   } pin_status_type;

   // SDA driven on ticks of a command: all low, all high or random
   localparam int SDA_LOW  = 0;
   localparam int SDA_HIGH = 1;
   localparam int SDA_RAND = 2;

   localparam int RANDOM_TICKS = 320;

   // ---------------------------------------------------------------------
   // DUT connections, all known from time zero
   // ---------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [9:0]  csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [7:0] tx_data, [8] master_ack, [9] sda_in
   logic [2:0]  req_tuser  = '0;   // [2:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [0] scl, [1] sda_release, [2] busy,
                                   // [3] done, [11:4] rx_data, [12] nack_seen

   i2c_bus_master_bit_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the sequencer and its half period
   // ---------------------------------------------------------------------
   logic [9:0] half_cfg;
   phase_type  seq_phase;
   logic [9:0] tick_cnt;
   logic [3:0] bits_rem;
   logic [7:0] shreg;
   logic       ack_bit;
   logic       pin_scl;
   logic       pin_sda;
   logic [7:0] rx_last;
   logic       nack_last;

   pin_status_type pin_status_q[$];    // expected status, oldest first
   int             mismatch_count = 0;
   int             ticks_sent     = 0;

   // sender pacing: bursts of ticks, gaps of random length up to gap_max (0: no gaps)
   int gap_max    = 0;
   int burst_left = 0;
   // receiver pacing: random stall percentage plus an explicit hold-off
   int stall_pct  = 0;
   int hold_left  = 0;

   function automatic void predictor_reset();
      half_cfg  = HALF_PERIOD_RESET;
      seq_phase = PH_IDLE;
      tick_cnt  = '0;
      bits_rem  = '0;
      shreg     = '0;
      ack_bit   = 1'b0;
      pin_scl   = 1'b1;
      pin_sda   = 1'b1;
      rx_last   = '0;
      nack_last = 1'b0;
   endfunction

   // zero means one tick; anything past the counter range is clipped
   function automatic void arm(phase_type next);
      if (half_cfg == '0)
         tick_cnt = 10'd1;
      else if (32'(half_cfg) > WAIT_MAX)
         tick_cnt = WAIT_MAX[9:0];
      else
         tick_cnt = half_cfg;
      seq_phase = next;
   endfunction

   // drive the MSB of the shift register onto SDA
   function automatic void shift_out();
      pin_sda = shreg[7];
      shreg   = {shreg[6:0], 1'b0};
      if (bits_rem != 0) bits_rem--;
   endfunction

   // one bus tick: advance the sequencer, return the pin/status snapshot
   function automatic pin_status_type bus_tick(logic [2:0] act, logic [7:0] tx,
                                               logic mack, logic sda_in);
      pin_status_type st;
      logic           fin;
      fin = 1'b0;
      if (seq_phase != PH_IDLE) begin
         if (tick_cnt != 0) tick_cnt--;
         if (tick_cnt == 0) begin
            case (seq_phase)
               PH_S_SCLH: begin pin_scl = 1'b1; arm(PH_S_SDAL); end
               PH_S_SDAL: begin pin_sda = 1'b0; arm(PH_S_SCLL); end
               PH_S_SCLL: begin pin_scl = 1'b0; seq_phase = PH_IDLE; fin = 1'b1; end
               PH_P_SCLH: begin pin_scl = 1'b1; arm(PH_P_SDAH); end
               PH_P_SDAH: begin pin_sda = 1'b1; arm(PH_P_END); end
               PH_P_END:  begin seq_phase = PH_IDLE; fin = 1'b1; end
               PH_T_LOW:  begin pin_scl = 1'b0; shift_out(); arm(PH_T_HIGH); end
               PH_T_HIGH: begin
                  pin_scl = 1'b1;
                  arm(bits_rem != 0 ? PH_T_LOW : PH_TA_LOW);
               end
               PH_TA_LOW: begin
                  pin_scl = 1'b0;
                  pin_sda = 1'b1;
                  arm(PH_TA_HIGH);
               end
               PH_TA_HIGH: begin pin_scl = 1'b1; arm(PH_TA_SAMPLE); end
               PH_TA_SAMPLE: begin
                  nack_last = sda_in;
                  pin_scl   = 1'b0;
                  seq_phase = PH_IDLE;
                  fin       = 1'b1;
               end
               PH_R_HIGH: begin pin_scl = 1'b1; arm(PH_R_SAMPLE); end
               PH_R_SAMPLE: begin
                  shreg = {shreg[6:0], sda_in};
                  if (bits_rem != 0) bits_rem--;
                  pin_scl = 1'b0;
                  if (bits_rem != 0) begin
                     arm(PH_R_HIGH);
                  end else begin
                     pin_sda = ~ack_bit;
                     arm(PH_RA_HIGH);
                  end
               end
               PH_RA_HIGH: begin pin_scl = 1'b1; arm(PH_RA_END); end
               PH_RA_END: begin
                  pin_scl   = 1'b0;
                  rx_last   = shreg;
                  seq_phase = PH_IDLE;
                  fin       = 1'b1;
               end
               default: seq_phase = PH_IDLE;
            endcase
         end
      end else begin
         // codes 5..7 fall through as no-ops
         case (act)
            ACT_START: begin pin_sda = 1'b1; arm(PH_S_SCLH); end
            ACT_STOP:  begin pin_sda = 1'b0; arm(PH_P_SCLH); end
            ACT_SEND: begin
               shreg    = tx;
               bits_rem = BITS_PER_BYTE;
               shift_out();
               arm(PH_T_HIGH);
            end
            ACT_RECEIVE: begin
               pin_sda  = 1'b1;
               shreg    = '0;
               bits_rem = BITS_PER_BYTE;
               ack_bit  = mack;
               arm(PH_R_HIGH);
            end
            default: ;
         endcase
      end
      st.scl     = pin_scl;
      st.sda_rel = pin_sda;
      st.busy    = (seq_phase != PH_IDLE);
      st.done    = fin;
      st.rx      = rx_last;
      st.nack    = nack_last;
      return st;
   endfunction

   // ---------------------------------------------------------------------
   // Mismatch reporting and the rsp checker
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] MISMATCH %s: got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : rsp_check
      pin_status_type exp_st;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pin_status_q.size() == 0) begin
            report_mismatch("rsp transaction with nothing pending", int'(rsp_tdata), 0);
         end else begin
            exp_st = pin_status_q.pop_front();
            if (rsp_tdata[0] !== exp_st.scl)
               report_mismatch("scl_out", int'(rsp_tdata[0]), int'(exp_st.scl));
            if (rsp_tdata[1] !== exp_st.sda_rel)
               report_mismatch("sda_release", int'(rsp_tdata[1]), int'(exp_st.sda_rel));
            if (rsp_tdata[2] !== exp_st.busy)
               report_mismatch("busy_res", int'(rsp_tdata[2]), int'(exp_st.busy));
            if (rsp_tdata[3] !== exp_st.done)
               report_mismatch("done_res", int'(rsp_tdata[3]), int'(exp_st.done));
            if (rsp_tdata[11:4] !== exp_st.rx)
               report_mismatch("rx_data", int'(rsp_tdata[11:4]), int'(exp_st.rx));
            if (rsp_tdata[12] !== exp_st.nack)
               report_mismatch("nack_seen", int'(rsp_tdata[12]), int'(exp_st.nack));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: explicit hold-off first, otherwise random stalls
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (stall_pct == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   // offer one tick, wait for the req transaction, then record the expectation
   task automatic send_tick(logic [2:0] act, logic [7:0] tx, logic mack, logic sda);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {6'b0, sda, mack, tx};
      do @(posedge clock); while (req_tready !== 1'b1);
      pin_status_q.push_back(bus_tick(act, tx, mack, sda));
      ticks_sent++;
      // burst over: drop valid for a gap of random length
      if (gap_max > 0) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(gap_max, 1)) @(posedge clock);
            burst_left = $urandom_range(16);
         end
      end
   endtask

   function automatic logic pick_sda(int mode);
      if (mode == SDA_LOW)  return 1'b0;
      if (mode == SDA_HIGH) return 1'b1;
      return 1'($urandom_range(1));
   endfunction

   // issue a command and keep ticking until the sequencer goes idle;
   // commands offered while busy are random and must be ignored
   task automatic run_command(logic [2:0] act, logic [7:0] tx, logic mack, int sda_mode);
      send_tick(act, tx, mack, pick_sda(sda_mode));
      while (seq_phase != PH_IDLE)
         send_tick(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                   pick_sda(sda_mode));
   endtask

   // stop offering and wait until every rsp transaction came back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pin_status_q.size() != 0) @(posedge clock);
   endtask

   // register write with the channel empty; the predictor follows at the edge
   task automatic set_half_period(logic [9:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      half_cfg = value;
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // reset half period: the first wait of a start runs the full 250 ticks,
   // then a short half period finishes it and a stop follows
   task automatic test_reset_period();
      gap_max   = 3;
      stall_pct = 20;
      send_tick(ACT_START, 8'h00, 1'b0, pick_sda(SDA_RAND));
      set_half_period(10'd1);
      while (seq_phase != PH_IDLE) send_tick(ACT_NONE, 8'h00, 1'b0, pick_sda(SDA_RAND));
      run_command(ACT_STOP, 8'h00, 1'b0, SDA_RAND);
   endtask

   // field extremes, every command, ignored codes, ack and nack both ways
   task automatic test_directed();
      gap_max   = 0;
      stall_pct = 0;
      set_half_period(10'd1);
      send_tick(3'd5, 8'hFF, 1'b1, 1'b1);             // undefined codes: no-op
      send_tick(3'd6, 8'h00, 1'b0, 1'b0);
      send_tick(3'd7, 8'h5A, 1'b1, 1'b0);
      run_command(ACT_START, 8'h00, 1'b0, SDA_LOW);
      run_command(ACT_SEND, 8'hFF, 1'b0, SDA_HIGH);   // slave NACKs
      run_command(ACT_SEND, 8'h00, 1'b1, SDA_LOW);    // slave ACKs
      run_command(ACT_RECEIVE, 8'hFF, 1'b1, SDA_HIGH);// read 0xFF, master ACK
      run_command(ACT_RECEIVE, 8'h00, 1'b0, SDA_LOW); // read 0x00, master NACK
      run_command(ACT_START, 8'hA5, 1'b1, SDA_RAND);  // repeated start
      run_command(ACT_STOP, 8'h00, 1'b0, SDA_RAND);
   endtask

   // zero half period acts as one tick
   task automatic test_zero_period();
      gap_max   = 2;
      stall_pct = 30;
      set_half_period(10'd0);
      run_command(ACT_START, 8'h00, 1'b0, SDA_RAND);
      run_command(ACT_SEND, 8'($urandom), 1'b0, SDA_RAND);
      run_command(ACT_RECEIVE, 8'h00, 1'($urandom_range(1)), SDA_RAND);
      run_command(ACT_STOP, 8'h00, 1'b0, SDA_RAND);
   endtask

   // new half period lands mid-byte, picked up at the next wait load
   task automatic test_mid_command_write();
      gap_max   = 0;
      stall_pct = 0;
      set_half_period(10'd2);
      send_tick(ACT_SEND, 8'hC3, 1'b0, 1'b0);
      repeat (5) send_tick(ACT_NONE, 8'h00, 1'b0, 1'b0);
      set_half_period(10'd3);
      while (seq_phase != PH_IDLE) send_tick(ACT_NONE, 8'h00, 1'b0, 1'($urandom_range(1)));
      send_tick(ACT_RECEIVE, 8'h00, 1'b1, 1'b1);
      repeat (7) send_tick(ACT_NONE, 8'h00, 1'b0, 1'($urandom_range(1)));
      set_half_period(10'd1);
      while (seq_phase != PH_IDLE) send_tick(ACT_NONE, 8'h00, 1'b0, 1'($urandom_range(1)));
   endtask

   // largest half period: the first wait of a start runs 1023 ticks,
   // the rest of the start runs at one tick
   task automatic test_max_period();
      gap_max   = 0;
      stall_pct = 10;
      set_half_period(10'd1023);
      send_tick(ACT_START, 8'h00, 1'b0, pick_sda(SDA_RAND));
      set_half_period(10'd1);
      while (seq_phase != PH_IDLE) send_tick(ACT_NONE, 8'h00, 1'b0, pick_sda(SDA_RAND));
   endtask

   // receiver holds off for a long stretch while ticks keep coming, so the
   // block fills up and has to drop req_tready
   task automatic test_backpressure();
      set_half_period(10'd1);
      gap_max   = 0;
      stall_pct = 0;
      hold_left = 80;
      run_command(ACT_SEND, 8'($urandom), 1'b0, SDA_RAND);
      run_command(ACT_RECEIVE, 8'h00, 1'($urandom_range(1)), SDA_RAND);
   endtask

   // mostly well-formed commands with random content, some noise ticks
   task automatic random_phase(logic [9:0] half, int gaps, int stalls, int n_ticks);
      logic [2:0] cmd_codes[4];
      int         stop_at;
      cmd_codes = '{ACT_START, ACT_STOP, ACT_SEND, ACT_RECEIVE};
      set_half_period(half);
      gap_max   = gaps;
      stall_pct = stalls;
      stop_at   = ticks_sent + n_ticks;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(9) < 8)
            run_command(cmd_codes[$urandom_range(3)], 8'($urandom),
                        1'($urandom_range(1)), SDA_RAND);
         else
            send_tick(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
      end
   endtask

   task automatic test_random();
      random_phase(10'd1, 0, 0,  RANDOM_TICKS / 4);
      random_phase(10'd2, 4, 30, RANDOM_TICKS / 4);
      random_phase(10'd3, 2, 0,  RANDOM_TICKS / 4);
      random_phase(10'd1, 0, 50, RANDOM_TICKS / 4);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      predictor_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_period();
      test_directed();
      test_zero_period();
      test_mid_command_write();
      test_max_period();
      test_backpressure();
      test_random();

      // all ticks offered; let the last rsp transactions come home
      req_tvalid <= 1'b0;
      for (int i = 0; i < 20000 && pin_status_q.size() != 0; i++) @(posedge clock);
      repeat (4) @(posedge clock);
      while (pin_status_q.size() != 0) begin
         report_mismatch("rsp transaction never arrived", 0, int'(pin_status_q[0]));
         void'(pin_status_q.pop_front());
      end

      if (mismatch_count == 0)
         $display("i2c_bus_master_bit_sequencer_tb OK");
      else
         $display("i2c_bus_master_bit_sequencer_tb NOT OK");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #1ms;
      $display("i2c_bus_master_bit_sequencer_tb NOT OK");
      $finish;
   end

endmodule
